// ----- src/hmis_pkg.sv -----
// ----------------------------------------------------------------------------
// hmis_pkg - shared types and constants of the heightmap sample unit
// Request and result payloads, request kinds and register map.
// ----------------------------------------------------------------------------
package hmis_pkg;

	// request kinds
	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// register map (word index on the configuration port)
	localparam int REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_GRID_ROWS   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_GRID_COLS   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_INV_SPACING = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_MIN_HEIGHT  = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_HEIGHT_SPAN = 3'd4;
	localparam int PADDR_W = 5;

	// register reset values
	localparam logic [8:0]         RST_GRID_ROWS   = 9'd256;
	localparam logic [8:0]         RST_GRID_COLS   = 9'd256;
	localparam logic [15:0]        RST_INV_SPACING = 16'd256;
	localparam logic signed [15:0] RST_MIN_HEIGHT  = 16'sd0;
	localparam logic signed [15:0] RST_HEIGHT_SPAN = 16'sd256;

	// smallest usable grid size along an axis
	localparam int MIN_GRID = 2;

	typedef struct packed {
		logic              kind;
		logic signed [19:0] x_coord;
		logic signed [19:0] z_coord;
		logic [7:0]         load_row;
		logic [7:0]         load_col;
		logic [15:0]        height_sample;
	} req_t;

	typedef struct packed {
		logic signed [31:0] height;
		logic [7:0]         row_index;
		logic [7:0]         col_index;
	} rsp_t;

endpackage

// ----- src/heightmap_interpolated_sample_unit.sv -----
// ----------------------------------------------------------------------------
// heightmap_interpolated_sample_unit - interpolated heightmap lookup
// Loads a grid of Q0.16 samples and returns bilinear-style heights in Q24.8.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on req when start is high and busy is low. busy stays
//   low: one request is taken every cycle. A load request writes one sample
//   of the grid and gives no result. A query request gives exactly one
//   result on the result port, marked by done for one cycle.
//   A query passes through an eight-register pipeline: coordinate multiply,
//   locate and clamp, table read, neighbor differences times fraction,
//   blend sum, span multiply in two partial products, rounding, offset and
//   saturation. Throughput is one request per cycle, set by the three-copy
//   sample store that reads the base sample and both neighbors at once.
//   Loads write the store at the same stage where queries read it, so
//   requests see the store in request order. The receiver cannot stall;
//   results are never held. Reset clears the pipeline valid bits and sets
//   the registers to their defaults; the sample store is not cleared and
//   must be loaded before it is queried. Configuration must be written on
//   the APB port only while no query is in flight; the block itself does
//   not enforce this.
// ----------------------------------------------------------------------------
module heightmap_interpolated_sample_unit #(
	parameter int GRID_DIM = 256
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  hmis_pkg::req_t                   req,
	output logic                             done,
	output hmis_pkg::rsp_t                   result,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [hmis_pkg::PADDR_W-1:0]     paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);

	localparam int IW = $clog2(GRID_DIM);
	localparam int SW = $clog2(GRID_DIM + 1);

	// ---------------- configuration registers ----------------
	logic [8:0]         grid_rows_q;
	logic [8:0]         grid_cols_q;
	logic [15:0]        inv_spacing_q;
	logic signed [15:0] min_height_q;
	logic signed [15:0] height_span_q;
	logic               cfg_wr;
	logic [hmis_pkg::REG_IDX_W-1:0] reg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = paddr[hmis_pkg::PADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_rows_q   <= hmis_pkg::RST_GRID_ROWS;
			grid_cols_q   <= hmis_pkg::RST_GRID_COLS;
			inv_spacing_q <= hmis_pkg::RST_INV_SPACING;
			min_height_q  <= hmis_pkg::RST_MIN_HEIGHT;
			height_span_q <= hmis_pkg::RST_HEIGHT_SPAN;
		end else if (cfg_wr) begin
			case (reg_idx)
				hmis_pkg::REG_GRID_ROWS:   grid_rows_q   <= pwdata[8:0];
				hmis_pkg::REG_GRID_COLS:   grid_cols_q   <= pwdata[8:0];
				hmis_pkg::REG_INV_SPACING: inv_spacing_q <= pwdata[15:0];
				hmis_pkg::REG_MIN_HEIGHT:  min_height_q  <= $signed(pwdata[15:0]);
				hmis_pkg::REG_HEIGHT_SPAN: height_span_q <= $signed(pwdata[15:0]);
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			hmis_pkg::REG_GRID_ROWS:   prdata = 32'(grid_rows_q);
			hmis_pkg::REG_GRID_COLS:   prdata = 32'(grid_cols_q);
			hmis_pkg::REG_INV_SPACING: prdata = 32'(inv_spacing_q);
			hmis_pkg::REG_MIN_HEIGHT:  prdata = 32'(min_height_q);
			hmis_pkg::REG_HEIGHT_SPAN: prdata = 32'(height_span_q);
			default:                   prdata = '0;
		endcase
	end

	// Clamp a configured grid size into the range the store supports.
	function automatic logic [SW-1:0] clamp_size(input logic [8:0] s);
		logic [SW-1:0] r;
		if (32'(s) < hmis_pkg::MIN_GRID) begin
			r = SW'(hmis_pkg::MIN_GRID);
		end else if (32'(s) > GRID_DIM) begin
			r = SW'(GRID_DIM);
		end else begin
			r = SW'(s);
		end
		return r;
	endfunction

	logic [SW-1:0] rows_size;
	logic [SW-1:0] cols_size;

	assign rows_size = clamp_size(grid_rows_q);
	assign cols_size = clamp_size(grid_cols_q);

	// ---------------- request acceptance ----------------
	logic accept;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	// ---------------- stage 1: coordinate multiply, load capture ----------------
	logic        qv_s1;
	logic        ld_s1;
	logic [IW-1:0] lrow_s1;
	logic [IW-1:0] lcol_s1;
	logic [15:0] lsamp_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qv_s1 <= 1'b0;
			ld_s1 <= 1'b0;
		end else begin
			qv_s1 <= accept && (req.kind == hmis_pkg::KIND_QUERY);
			// drop loads that fall outside the table
			ld_s1 <= accept && (req.kind == hmis_pkg::KIND_LOAD)
				&& (32'(req.load_row) < GRID_DIM) && (32'(req.load_col) < GRID_DIM);
		end
	end

	always_ff @(posedge clk) begin
		lrow_s1  <= IW'(req.load_row);
		lcol_s1  <= IW'(req.load_col);
		lsamp_s1 <= req.height_sample;
	end

	// ---------------- stages 1-2: locate along each axis ----------------
	logic [IW-1:0] i_s2;
	logic [IW-1:0] j_s2;
	logic [15:0]   fx_s2;
	logic [15:0]   fz_s2;

	hmis_axis #(.GRID_DIM(GRID_DIM)) u_axis_x (
		.clk         (clk),
		.coord       (req.x_coord),
		.inv_spacing (inv_spacing_q),
		.size        (rows_size),
		.idx_s2      (i_s2),
		.frac_s2     (fx_s2)
	);

	hmis_axis #(.GRID_DIM(GRID_DIM)) u_axis_z (
		.clk         (clk),
		.coord       (req.z_coord),
		.inv_spacing (inv_spacing_q),
		.size        (cols_size),
		.idx_s2      (j_s2),
		.frac_s2     (fz_s2)
	);

	logic          qv_s2;
	logic          ld_s2;
	logic [IW-1:0] lrow_s2;
	logic [IW-1:0] lcol_s2;
	logic [15:0]   lsamp_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qv_s2 <= 1'b0;
			ld_s2 <= 1'b0;
		end else begin
			qv_s2 <= qv_s1;
			ld_s2 <= ld_s1;
		end
	end

	always_ff @(posedge clk) begin
		lrow_s2  <= lrow_s1;
		lcol_s2  <= lcol_s1;
		lsamp_s2 <= lsamp_s1;
	end

	// ---------------- stage 3: sample store access ----------------
	// Loads write and queries read at this same stage, keeping request order.
	logic [IW-1:0] i_nx;
	logic [IW-1:0] j_nx;
	logic [15:0]   h0_s3;
	logic [15:0]   h1_s3;
	logic [15:0]   h2_s3;

	assign i_nx = i_s2 + IW'(1);
	assign j_nx = j_s2 + IW'(1);

	hmis_table #(.GRID_DIM(GRID_DIM)) u_table (
		.clk      (clk),
		.wr_en    (ld_s2),
		.wr_addr  ({lrow_s2, lcol_s2}),
		.wr_data  (lsamp_s2),
		.rd_addr0 ({i_s2, j_s2}),
		.rd_addr1 ({i_nx, j_s2}),
		.rd_addr2 ({i_s2, j_nx}),
		.rd_data0 (h0_s3),
		.rd_data1 (h1_s3),
		.rd_data2 (h2_s3)
	);

	logic          qv_s3;
	logic [IW-1:0] i_s3;
	logic [IW-1:0] j_s3;
	logic [15:0]   fx_s3;
	logic [15:0]   fz_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qv_s3 <= 1'b0;
		end else begin
			qv_s3 <= qv_s2;
		end
	end

	always_ff @(posedge clk) begin
		i_s3  <= i_s2;
		j_s3  <= j_s2;
		fx_s3 <= fx_s2;
		fz_s3 <= fz_s2;
	end

	// ---------------- stage 4: neighbor differences times fraction ----------------
	logic signed [16:0] dx;
	logic signed [16:0] dz;
	logic               qv_s4;
	logic [IW-1:0]      i_s4;
	logic [IW-1:0]      j_s4;
	logic [15:0]        h0_s4;
	logic signed [33:0] px_s4;
	logic signed [33:0] pz_s4;

	// Drop the neighbor when its fraction is zero: at the last index it may
	// lie outside the loaded grid.
	assign dx = (fx_s3 == 16'd0) ? 17'sd0
		: ($signed({1'b0, h1_s3}) - $signed({1'b0, h0_s3}));
	assign dz = (fz_s3 == 16'd0) ? 17'sd0
		: ($signed({1'b0, h2_s3}) - $signed({1'b0, h0_s3}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qv_s4 <= 1'b0;
		end else begin
			qv_s4 <= qv_s3;
		end
	end

	always_ff @(posedge clk) begin
		i_s4  <= i_s3;
		j_s4  <= j_s3;
		h0_s4 <= h0_s3;
		px_s4 <= $signed({1'b0, fx_s3}) * dx;
		pz_s4 <= $signed({1'b0, fz_s3}) * dz;
	end

	// ---------------- stage 5: blend sum, Q3.32 ----------------
	logic               qv_s5;
	logic [IW-1:0]      i_s5;
	logic [IW-1:0]      j_s5;
	logic signed [34:0] v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qv_s5 <= 1'b0;
		end else begin
			qv_s5 <= qv_s4;
		end
	end

	always_ff @(posedge clk) begin
		i_s5 <= i_s4;
		j_s5 <= j_s4;
		v_s5 <= $signed({3'b0, h0_s4, 16'b0}) + 35'(px_s4) + 35'(pz_s4);
	end

	// ---------------- stage 6: span multiply as two partial products ----------------
	logic               qv_s6;
	logic [IW-1:0]      i_s6;
	logic [IW-1:0]      j_s6;
	logic signed [34:0] pl_s6;
	logic signed [32:0] ph_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qv_s6 <= 1'b0;
		end else begin
			qv_s6 <= qv_s5;
		end
	end

	always_ff @(posedge clk) begin
		i_s6  <= i_s5;
		j_s6  <= j_s5;
		pl_s6 <= $signed({1'b0, v_s5[17:0]}) * height_span_q;
		ph_s6 <= $signed(v_s5[34:18]) * height_span_q;
	end

	// ---------------- stage 7: recombine and round to Q.8 ----------------
	// Add half an output LSB, then floor: ties round toward plus infinity.
	logic signed [51:0] p_full;
	logic               qv_s7;
	logic [IW-1:0]      i_s7;
	logic [IW-1:0]      j_s7;
	logic signed [27:0] q_s7;

	assign p_full = (52'(ph_s6) <<< 18) + 52'(pl_s6) + 52'sd8388608;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qv_s7 <= 1'b0;
		end else begin
			qv_s7 <= qv_s6;
		end
	end

	always_ff @(posedge clk) begin
		i_s7 <= i_s6;
		j_s7 <= j_s6;
		q_s7 <= p_full[51:24];
	end

	// ---------------- stage 8: offset, saturate, output register ----------------
	logic signed [33:0] res_full;
	logic signed [31:0] res_sat;

	assign res_full = 34'(q_s7) + (34'(min_height_q) <<< 8);

	always_comb begin
		if (res_full > 34'sd2147483647) begin
			res_sat = 32'sh7fffffff;
		end else if (res_full < -34'sd2147483648) begin
			res_sat = 32'sh80000000;
		end else begin
			res_sat = res_full[31:0];
		end
	end

	logic           done_q;
	hmis_pkg::rsp_t result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= qv_s7;
		end
	end

	always_ff @(posedge clk) begin
		result_q.height    <= res_sat;
		result_q.row_index <= 8'(i_s7);
		result_q.col_index <= 8'(j_s7);
	end

	assign done   = done_q;
	assign result = result_q;

	// ---------------- assertions ----------------
	// every result traces back to a query that was taken earlier
	a_result_has_query: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept && (req.kind == hmis_pkg::KIND_QUERY), 8))
		else $error("result without matching query");

	// a query taken must produce a result
	a_query_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req.kind == hmis_pkg::KIND_QUERY)) |-> ##8 done)
		else $error("query result lost");

	// store access stage holds at most one request
	a_store_stage_single: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({qv_s2, ld_s2}))
		else $error("load and query share the store stage");

	// reported base row stays inside the table
	a_row_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((32'(result.row_index) < GRID_DIM) || (GRID_DIM > 256)))
		else $error("row index outside table");

endmodule

// ----- src/hmis_axis.sv -----
// ----------------------------------------------------------------------------
// hmis_axis - grid locator for one axis
// Scales a coordinate by the inverse spacing, offsets by half the grid and
// clamps to a base index plus the fraction used by the blend (two stages).
// ----------------------------------------------------------------------------
module hmis_axis #(
	parameter int GRID_DIM = 256
) (
	input  logic                              clk,
	input  logic signed [19:0]                coord,
	input  logic [15:0]                       inv_spacing,
	input  logic [$clog2(GRID_DIM+1)-1:0]     size,
	output logic [$clog2(GRID_DIM)-1:0]       idx_s2,
	output logic [15:0]                       frac_s2
);

	localparam int IW = $clog2(GRID_DIM);

	logic signed [36:0] prod_s1;
	logic signed [36:0] offset;
	logic signed [36:0] t;
	logic [20:0]        ip;
	logic [20:0]        lim;
	logic [IW-1:0]      idx_n;
	logic [15:0]        frac_n;

	always_ff @(posedge clk) begin
		prod_s1 <= $signed(coord) * $signed({1'b0, inv_spacing});
	end

	always_comb begin
		offset = $signed({21'(size >> 1), 16'b0});
		t      = prod_s1 + offset;
		ip     = t[36:16];
		lim    = 21'(size) - 21'd1;
		if (t[36]) begin
			// below the grid: base cell zero, no fraction
			idx_n  = '0;
			frac_n = '0;
		end else if (ip > lim) begin
			// past the last index: no term along this axis
			idx_n  = IW'(lim);
			frac_n = '0;
		end else begin
			idx_n  = IW'(ip);
			// the last index adds no term either
			frac_n = (ip < lim) ? t[15:0] : 16'd0;
		end
	end

	always_ff @(posedge clk) begin
		idx_s2  <= idx_n;
		frac_s2 <= frac_n;
	end

endmodule

// ----- src/hmis_table.sv -----
// ----------------------------------------------------------------------------
// hmis_table - sample store
// Three copies of the sample grid share one write port so the base sample
// and both neighbors are read in the same cycle; read data is registered.
// ----------------------------------------------------------------------------
module hmis_table #(
	parameter int GRID_DIM = 256
) (
	input  logic                              clk,
	input  logic                              wr_en,
	input  logic [2*$clog2(GRID_DIM)-1:0]     wr_addr,
	input  logic [15:0]                       wr_data,
	input  logic [2*$clog2(GRID_DIM)-1:0]     rd_addr0,
	input  logic [2*$clog2(GRID_DIM)-1:0]     rd_addr1,
	input  logic [2*$clog2(GRID_DIM)-1:0]     rd_addr2,
	output logic [15:0]                       rd_data0,
	output logic [15:0]                       rd_data1,
	output logic [15:0]                       rd_data2
);

	localparam int AW    = 2 * $clog2(GRID_DIM);
	localparam int DEPTH = 1 << AW;

	logic [15:0] mem0 [DEPTH];
	logic [15:0] mem1 [DEPTH];
	logic [15:0] mem2 [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem0[wr_addr] <= wr_data;
			mem1[wr_addr] <= wr_data;
			mem2[wr_addr] <= wr_data;
		end
		rd_data0 <= mem0[rd_addr0];
		rd_data1 <= mem1[rd_addr1];
		rd_data2 <= mem2[rd_addr2];
	end

endmodule
